FILE: design/phy_link_status_monitor_defines.svh
// Assertion macros shared by the checker of the link status monitor.
`ifndef PHY_LINK_STATUS_MONITOR_DEFINES_SVH
`define PHY_LINK_STATUS_MONITOR_DEFINES_SVH

// Implication in the same cycle, sampled on the rising clock edge.
`define PLM_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("link status monitor check failed");

// Implication in the next cycle, sampled on the rising clock edge.
`define PLM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("link status monitor check failed");

`endif

FILE: design/plm_pkg.sv
package plm_pkg;

    // Bit positions inside the sampled MII registers.
    localparam int unsigned CTL_SPEED_SEL_LO = 6;
    localparam int unsigned CTL_FULL_DUPLEX  = 8;
    localparam int unsigned CTL_AN_RESTART   = 9;
    localparam int unsigned CTL_AN_ENABLE    = 12;
    localparam int unsigned CTL_SPEED_SEL_HI = 13;
    localparam int unsigned STS_LINK         = 2;
    localparam int unsigned STS_AN_DONE      = 5;
    localparam int unsigned STS_EXT_STATUS   = 8;
    localparam int unsigned GIG_LP_1000H     = 10;
    localparam int unsigned GIG_LP_1000F     = 11;
    localparam int unsigned GIG_MS_FAULT     = 15;
    localparam int unsigned LPA_10H          = 5;

    localparam int unsigned MODE_W      = 6;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 6;
    localparam logic [MODE_W-1:0] ADV_RESET = 6'h3F;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MONITOR_ENABLE   = 2'd0,
        REG_ADVERTISED_MODES = 2'd1
    } reg_index_t;

    typedef enum logic [1:0] {
        SPD_NONE = 2'd0,
        SPD_10M  = 2'd1,
        SPD_100M = 2'd2,
        SPD_1G   = 2'd3
    } speed_t;

    typedef enum logic [1:0] {
        DPX_NONE = 2'd0,
        DPX_HALF = 2'd1,
        DPX_FULL = 2'd2
    } duplex_t;

    typedef enum logic [1:0] {
        FAULT_NONE    = 2'd0,
        FAULT_MS      = 2'd1,
        FAULT_IGNORED = 2'd2
    } fault_t;

    typedef struct packed {
        logic [15:0] partner_ability;
        logic [15:0] gig_status;
        logic [15:0] basic_status;
        logic [15:0] basic_control;
    } item_t;

    typedef struct packed {
        logic [1:0]        fault_code;
        logic [MODE_W-1:0] partner_modes;
        logic              autoneg_on;
        logic [1:0]        duplex_code;
        logic [1:0]        speed_code;
        logic              link_changed;
        logic              link_up;
    } result_t;

    typedef struct packed {
        logic              link_flag;
        logic              reported_up;
        speed_t            speed;
        duplex_t           duplex;
        logic              autoneg;
        logic [MODE_W-1:0] partner;
    } state_t;

    typedef struct packed {
        logic              enable;
        logic [MODE_W-1:0] advertised;
        logic              report_clear;
    } cfg_t;

endpackage

FILE: design/phy_link_status_monitor.sv
// Link status monitor for a Clause 22 MII PHY.
//
// Poll transactions arrive on the s_ stream: each carries sampled copies of
// the control, status, 1000BASE-T status and link partner ability registers.
// Every poll produces exactly one result transaction on the m_ stream with
// the link flag, a change flag for software, the resolved speed and duplex,
// the autoneg mode, the captured partner abilities and a fault code.
// The cfg_ channel writes monitor_enable (index 0) and advertised_modes
// (index 1); it is always ready and should only be used while no poll is in
// flight. Other indices are ignored.
// A poll is held in an input register, resolved against the stored link
// state and written to the result register, which drives m_tvalid and
// m_tdata; while the receiver does not stall, one poll is taken every cycle.
// If the receiver stalls, the result register holds its transaction and the
// input register absorbs one more poll before s_tready falls.
// Reset clears the stored link state, disables monitoring and sets the
// advertised modes to all six abilities.
module phy_link_status_monitor
    import plm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // basic_control[15:0], basic_status[31:16], gig_status[47:32],
    // partner_ability[63:48]
    input  logic [63:0]            s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // link_up[0], link_changed[1], speed_code[3:2], duplex_code[5:4],
    // autoneg_on[6], partner_modes[12:7], fault_code[14:13], zero pad[15]
    output logic [15:0]            m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t    cfg;
    item_t   item_reg;
    logic    item_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t result_next;
    result_t result_reg;
    logic    result_valid_reg;
    logic    advance;

    plm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    plm_resolve u_resolve (
        .item       (item_reg),
        .state      (state_reg),
        .cfg        (cfg),
        .state_next (state_next),
        .result     (result_next)
    );

    // A poll moves on whenever the result register is empty or being drained.
    assign advance  = item_valid_reg & (~result_valid_reg | m_tready);
    assign s_tready = ~item_valid_reg | advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            state_reg        <= '0;
        end
        else
        begin
            if (s_tready)
                item_valid_reg <= s_tvalid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (m_tready)
                result_valid_reg <= 1'b0;
            if (advance)
                state_reg <= state_next;
            else if (cfg.report_clear)
                state_reg.reported_up <= 1'b0;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            item_reg <= item_t'(s_tdata);
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = {1'b0, result_reg};

endmodule

FILE: design/plm_cfg.sv
module plm_cfg
    import plm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    logic              enable_reg;
    logic              enable_next;
    logic [MODE_W-1:0] adv_reg;
    logic [MODE_W-1:0] adv_next;
    logic              wr;

    assign cfg_ready = 1'b1;
    assign wr        = cfg_valid & cfg_ready;

    always_comb
    begin
        enable_next = enable_reg;
        adv_next    = adv_reg;
        if (wr)
        begin
            case (reg_index_t'(cfg_index))
                REG_MONITOR_ENABLE:   enable_next = cfg_data[0];
                REG_ADVERTISED_MODES: adv_next    = cfg_data[MODE_W-1:0];
                default:              ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            adv_reg    <= ADV_RESET;
        end
        else
        begin
            enable_reg <= enable_next;
            adv_reg    <= adv_next;
        end
    end

    // Enabling clears reported_up unless a poll moves on.
    assign cfg.enable       = enable_reg;
    assign cfg.advertised   = adv_reg;
    assign cfg.report_clear = enable_next & ~enable_reg;

endmodule

FILE: design/plm_resolve.sv
module plm_resolve
    import plm_pkg::*;
(
    input  item_t   item,
    input  state_t  state,
    input  cfg_t    cfg,
    output state_t  state_next,
    output result_t result
);

    logic              an;
    logic              link_new;
    logic              rising;
    logic              ms_fault;
    logic [MODE_W-1:0] modes;
    logic [MODE_W-1:0] common;
    speed_t            an_speed;
    duplex_t           an_duplex;
    speed_t            forced_speed;
    logic [1:0]        sel;
    fault_t            fault;
    logic              changed;

    always_comb
    begin
        an       = item.basic_control[CTL_AN_ENABLE];
        link_new = ~item.basic_control[CTL_AN_RESTART]
                 & item.basic_status[STS_LINK] & item.basic_status[STS_AN_DONE];
        rising   = ~item.basic_control[CTL_AN_RESTART] & ~state.link_flag & link_new;
        ms_fault = an & item.basic_status[STS_EXT_STATUS] & item.gig_status[GIG_MS_FAULT];

        modes = {2'b00, item.partner_ability[LPA_10H+3:LPA_10H]};
        if (item.basic_status[STS_EXT_STATUS])
        begin
            modes[5] = item.gig_status[GIG_LP_1000F];
            modes[4] = item.gig_status[GIG_LP_1000H];
        end
        if (!an)
            modes = '0;

        // Highest common mode, 1000F first and 10H last.
        common = cfg.advertised & modes;
        if (common[5])      begin an_speed = SPD_1G;   an_duplex = DPX_FULL; end
        else if (common[4]) begin an_speed = SPD_1G;   an_duplex = DPX_HALF; end
        else if (common[3]) begin an_speed = SPD_100M; an_duplex = DPX_FULL; end
        else if (common[2]) begin an_speed = SPD_100M; an_duplex = DPX_HALF; end
        else if (common[1]) begin an_speed = SPD_10M;  an_duplex = DPX_FULL; end
        else if (common[0]) begin an_speed = SPD_10M;  an_duplex = DPX_HALF; end
        else                begin an_speed = SPD_NONE; an_duplex = DPX_NONE; end

        sel = {item.basic_control[CTL_SPEED_SEL_HI], item.basic_control[CTL_SPEED_SEL_LO]};
        case (sel)
            2'b01:   forced_speed = SPD_1G;
            2'b10:   forced_speed = SPD_100M;
            default: forced_speed = SPD_10M;
        endcase

        state_next = state;
        fault      = FAULT_NONE;
        changed    = 1'b0;
        if (!cfg.enable)
        begin
            fault = FAULT_IGNORED;
        end
        else
        begin
            state_next.autoneg   = an;
            state_next.link_flag = link_new;
            if (rising && ms_fault)
            begin
                fault = FAULT_MS;
            end
            else
            begin
                if (rising)
                begin
                    state_next.partner = modes;
                    if (an)
                    begin
                        state_next.speed  = an_speed;
                        state_next.duplex = an_duplex;
                    end
                    else
                    begin
                        state_next.speed  = forced_speed;
                        state_next.duplex = item.basic_control[CTL_FULL_DUPLEX]
                                          ? DPX_FULL : DPX_HALF;
                    end
                end
                if (link_new != state.reported_up)
                begin
                    state_next.reported_up = link_new;
                    changed                = 1'b1;
                end
            end
        end

        result.link_up       = state_next.link_flag;
        result.link_changed  = changed;
        result.speed_code    = state_next.speed;
        result.duplex_code   = state_next.duplex;
        result.autoneg_on    = state_next.autoneg;
        result.partner_modes = state_next.partner;
        result.fault_code    = fault;
    end

endmodule

FILE: design/plm_checker.sv
`include "phy_link_status_monitor_defines.svh"

module plm_checker
    import plm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata
);

    `PLM_ASSERT_SAME(a_fault_legal, m_tvalid, m_tdata[14:13] <= FAULT_IGNORED)
    `PLM_ASSERT_SAME(a_change_no_fault, m_tvalid && m_tdata[1], m_tdata[14:13] == FAULT_NONE)
    `PLM_ASSERT_SAME(a_speed_duplex_pair, m_tvalid,
        (m_tdata[3:2] == SPD_NONE) == (m_tdata[5:4] == DPX_NONE) && m_tdata[5:4] <= DPX_FULL)
    `PLM_ASSERT_NEXT(a_result_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

endmodule

bind phy_link_status_monitor plm_checker u_plm_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
